// ===== rtl/ple_pkg.sv =====
// ple_pkg: shared types, sizes and codes for the positional list engine.
// No dependencies; imported by the interfaces, the cell and the top level.
`default_nettype none

package ple_pkg;

    localparam int CAPACITY  = 64;
    localparam int WORD_BITS = 32;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > 7) ? CNT_W : 7) + 1;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [CMP_W-1:0]     cmp_t;

    typedef logic [2:0]           req_type_t;
    typedef logic signed [31:0]   data_t;
    typedef logic [6:0]           pos_t;
    typedef logic [1:0]           status_t;

    localparam req_type_t REQ_PUSH_FRONT = 3'd0;
    localparam req_type_t REQ_PUSH_BACK  = 3'd1;
    localparam req_type_t REQ_POP_FRONT  = 3'd2;
    localparam req_type_t REQ_POP_BACK   = 3'd3;
    localparam req_type_t REQ_INSERT     = 3'd4;
    localparam req_type_t REQ_REMOVE     = 3'd5;
    localparam req_type_t REQ_READ       = 3'd6;
    localparam req_type_t REQ_CLEAR      = 3'd7;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_RANGE = 2'd2;
    localparam status_t ST_FULL  = 2'd3;

    // Broadcast control for the cell row.
    typedef struct packed {
        logic ins;   // open a slot at idx, cells above take left neighbor
        logic del;   // close slot idx, cells at and above take right neighbor
        cmp_t idx;   // zero-based target slot
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/ple_if.sv =====
// Request and response channel interfaces for the positional list engine.
// Depends on ple_pkg.
`default_nettype none

interface list_req_if;
    import ple_pkg::*;

    logic      valid;
    logic      ready;
    req_type_t req_type;
    data_t     value;
    pos_t      position;

    modport source (output valid, output req_type, output value, output position,
                    input ready);
    modport sink   (input valid, input req_type, input value, input position,
                    output ready);
endinterface

interface list_rsp_if;
    import ple_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    data_t   read_value;
    pos_t    count;

    modport source (output valid, output status, output read_value, output count,
                    input ready);
    modport sink   (input valid, input status, input read_value, input count,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/ple_cell.sv =====
// ple_cell: one slot of the list row; shifts toward or away from its neighbors.
// Depends on ple_pkg.
`default_nettype none

module ple_cell (
    input  wire logic               clk,
    input  wire ple_pkg::idx_t      cell_index,
    input  wire ple_pkg::cell_ctl_t ctl,
    input  wire ple_pkg::word_t     new_word,
    input  wire ple_pkg::word_t     left_word,
    input  wire ple_pkg::word_t     right_word,
    output ple_pkg::word_t          word,
    output ple_pkg::word_t          hit_word
);
    import ple_pkg::*;

    word_t data_reg;
    word_t data_next;
    cmp_t  my_idx;
    logic  at_idx;
    logic  above_idx;

    assign my_idx    = CMP_W'(cell_index);
    assign at_idx    = (my_idx == ctl.idx);
    assign above_idx = (my_idx > ctl.idx);

    always_comb
    begin
        data_next = data_reg;
        if (ctl.ins)
        begin
            if (at_idx)
                data_next = new_word;
            else if (above_idx)
                data_next = left_word;
        end
        else if (ctl.del)
        begin
            if (at_idx || above_idx)
                data_next = right_word;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign word     = data_reg;
    // gated so the top can OR all cells into one read bus
    assign hit_word = at_idx ? data_reg : '0;

endmodule

`default_nettype wire

// ===== rtl/positional_list_engine_top.sv =====
// positional_list_engine_top: ordered word store built as a row of shifting cells.
// Depends on ple_pkg, ple_if (list_req_if, list_rsp_if) and ple_cell.
`default_nettype none

// The engine holds up to CAPACITY words in a row of cells, slot 0 at the front.
// Every request transfer on req yields exactly one response transfer on rsp,
// in order: status, the word read (zero unless a read succeeded) and the new
// count. Insert and remove shift every cell above the target slot by one place
// in the same clock; the response is written into the output register at
// the request transfer, and a new request is taken in every cycle in which
// that register is empty or being drained, i.e. one request per cycle
// sustained. The read path is one CAPACITY-wide OR of gated cell words into
// the response register. Cell contents have no reset; only slots below the
// count are ever read, and a clear just zeroes the count.

module positional_list_engine_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    list_req_if.sink    req,
    list_rsp_if.source  rsp
);
    import ple_pkg::*;

    // occupancy and response register
    cnt_t      cnt_reg;
    cnt_t      cnt_next;
    logic      rsp_valid_reg;
    status_t   status_reg;
    status_t   status_next;
    data_t     rdval_reg;
    data_t     rdval_next;

    logic      xfer;
    cell_ctl_t ctl;
    word_t     new_word;
    word_t     cell_word [CAPACITY];
    word_t     cell_hit  [CAPACITY];
    word_t     hit_bus;
    logic [63:0] rd_ext;

    cmp_t cnt_ext;
    cmp_t pos_ext;
    logic full;
    logic empty;
    logic pos_ok;       // 1..count
    logic pos_ok_ins;   // 1..count+1

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign xfer      = req.valid && req.ready;

    assign cnt_ext    = CMP_W'(cnt_reg);
    assign pos_ext    = CMP_W'(req.position);
    assign full       = (cnt_ext >= CMP_W'(CAPACITY));
    assign empty      = (cnt_reg == '0);
    assign pos_ok     = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign pos_ok_ins = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));

    // sign extend the 32-bit input, keep the low WORD_BITS
    assign new_word = WORD_BITS'({{32{req.value[31]}}, req.value});

    // request decode: control for the cell row, status, next count
    always_comb
    begin
        ctl         = '0;
        ctl.idx     = pos_ext - CMP_W'(1);
        status_next = ST_OK;
        cnt_next    = cnt_reg;
        unique case (req.req_type)
            REQ_PUSH_FRONT, REQ_PUSH_BACK:
            begin
                ctl.idx = (req.req_type == REQ_PUSH_FRONT) ? '0 : cnt_ext;
                if (full)
                    status_next = ST_FULL;
                else
                begin
                    ctl.ins  = 1'b1;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            REQ_POP_FRONT, REQ_POP_BACK:
            begin
                ctl.idx = (req.req_type == REQ_POP_FRONT) ? '0 : cnt_ext - CMP_W'(1);
                if (empty)
                    status_next = ST_EMPTY;
                else
                begin
                    ctl.del  = 1'b1;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            REQ_INSERT:
            begin
                // range is checked before fullness
                if (!pos_ok_ins)
                    status_next = ST_RANGE;
                else if (full)
                    status_next = ST_FULL;
                else
                begin
                    ctl.ins  = 1'b1;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            REQ_REMOVE:
            begin
                if (!pos_ok)
                    status_next = ST_RANGE;
                else
                begin
                    ctl.del  = 1'b1;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            REQ_READ:
            begin
                if (!pos_ok)
                    status_next = ST_RANGE;
            end
            REQ_CLEAR:
            begin
                cnt_next = '0;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
        if (!xfer)
        begin
            ctl.ins = 1'b0;
            ctl.del = 1'b0;
        end
    end

    // the row of cells; end cells see zero beyond the row
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        word_t left_w;
        word_t right_w;
        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = cell_word[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = cell_word[i+1];
        end

        ple_cell u_cell (
            .clk        (clk),
            .cell_index (IDX_W'(i)),
            .ctl        (ctl),
            .new_word   (new_word),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (cell_word[i]),
            .hit_word   (cell_hit[i])
        );
    end

    // read bus: at most one cell matches the target slot
    always_comb
    begin
        hit_bus = '0;
        for (int k = 0; k < CAPACITY; k++)
            hit_bus = hit_bus | cell_hit[k];
    end

    assign rd_ext     = 64'(signed'(hit_bus));
    assign rdval_next = (req.req_type == REQ_READ && pos_ok) ? rd_ext[31:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (xfer)
            begin
                cnt_reg       <= cnt_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (xfer)
        begin
            status_reg <= status_next;
            rdval_reg  <= rdval_next;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.read_value = rdval_reg;
    assign rsp.count      = 7'(cnt_reg);

    // occupancy never passes the row length
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(cnt_reg) <= CMP_W'(CAPACITY))
        else $error("count exceeds capacity");

    // a clear always answers ok with an empty store
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && req.req_type == REQ_CLEAR) |=>
        (rsp.valid && rsp.status == ST_OK && cnt_reg == '0))
        else $error("clear response wrong");

    // full status only reported while the row is full
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_FULL) |-> (CMP_W'(cnt_reg) == CMP_W'(CAPACITY)))
        else $error("full status with free slots");

    // a failed request leaves the count alone
    a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && status_next != ST_OK) |=> (cnt_reg == $past(cnt_reg)))
        else $error("rejected request changed count");

endmodule

`default_nettype wire
